// File: rtl/sitda_pkg.sv
// Shared types and constants for the signed integer to decimal text converter.
`timescale 1ns / 1ps

package sitda_pkg;

  localparam int VALUE_W    = 32;
  localparam int NUM_DIGITS = 10;
  localparam int BCD_W      = 4 * NUM_DIGITS;
  localparam int CHAR_W     = 6;
  localparam int IDX_W      = 4;

  localparam logic [CHAR_W-1:0] CHAR_MINUS = 6'd45;
  localparam logic [CHAR_W-1:0] CHAR_ZERO  = 6'd48;

  typedef logic [BCD_W-1:0] bcd_t;

  // Converted number handed from the converter side to the character sequencer.
  typedef struct packed {
    logic neg;
    bcd_t bcd;
  } num_t;

endpackage

// File: rtl/sitda_bcd.sv
// Iterative shift-and-add-3 binary to BCD converter, one bit per cycle.
`timescale 1ns / 1ps

module sitda_bcd
  import sitda_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic [VALUE_W-1:0] mag,
  output logic               done,
  output bcd_t               bcd
);

  localparam logic [4:0] LAST_STEP = 5'(VALUE_W - 1);

  logic [VALUE_W-1:0] shreg;
  logic [4:0]         cnt;
  logic               run;
  bcd_t               adj;

  // Every digit that is five or more gets three added before the shift.
  always_comb begin
    for (int i = 0; i < NUM_DIGITS; i++) begin
      if (bcd[i*4 +: 4] >= 4'd5) begin
        adj[i*4 +: 4] = bcd[i*4 +: 4] + 4'd3;
      end else begin
        adj[i*4 +: 4] = bcd[i*4 +: 4];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        run <= 1'b1;
        cnt <= '0;
      end else if (run) begin
        cnt <= cnt + 5'd1;
        if (cnt == LAST_STEP) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      shreg <= mag;
      bcd   <= '0;
    end else if (run) begin
      shreg <= {shreg[VALUE_W-2:0], 1'b0};
      bcd   <= {adj[BCD_W-2:0], shreg[VALUE_W-1]};
    end
  end

endmodule

// File: rtl/sitda_emit.sv
// Character sequencer: sends the sign and the significant digits, one beat each.
`timescale 1ns / 1ps

module sitda_emit
  import sitda_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  num_t              num,
  output logic              busy,
  output logic              m_tvalid,
  input  logic              m_tready,
  output logic [7:0]        m_tdata,   // [5:0] character, [7:6] zero
  output logic              m_tlast
);

  logic             active;
  logic             neg_pend;
  bcd_t             bcd;
  logic [IDX_W-1:0] idx;
  logic [IDX_W-1:0] first_idx;
  logic [3:0]       digit;
  logic [CHAR_W-1:0] character;
  logic             load;

  // Highest nonzero digit; zero itself still sends the lowest digit.
  always_comb begin
    first_idx = '0;
    for (int i = 0; i < NUM_DIGITS; i++) begin
      if (num.bcd[i*4 +: 4] != 4'd0) begin
        first_idx = IDX_W'(i);
      end
    end
  end

  assign digit = bcd[idx*4 +: 4];
  assign load  = active && (!m_tvalid || m_tready);
  assign busy  = active || m_tvalid;
  assign m_tdata = {2'b00, character};

  always_ff @(posedge clk) begin
    if (rst) begin
      active   <= 1'b0;
      m_tvalid <= 1'b0;
      neg_pend <= 1'b0;
    end else begin
      if (load) begin
        m_tvalid <= 1'b1;
      end else if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      if (start) begin
        active   <= 1'b1;
        neg_pend <= num.neg;
      end else if (load) begin
        if (neg_pend) begin
          neg_pend <= 1'b0;
        end else if (idx == '0) begin
          active <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      bcd <= num.bcd;
      idx <= first_idx;
    end else if (load) begin
      if (neg_pend) begin
        character <= CHAR_MINUS;
        m_tlast   <= 1'b0;
      end else begin
        character <= CHAR_ZERO + {2'b00, digit};
        m_tlast   <= (idx == '0);
        if (idx != '0) begin
          idx <= idx - 1'b1;
        end
      end
    end
  end

endmodule

// File: rtl/signed_int_to_decimal_ascii_core.sv
// Top level of the signed 32-bit integer to decimal ASCII converter.
// Usage:
//   Input channel s_t*: one beat carries a two's complement 32-bit value.
//   Output channel m_t*: one beat per character, most significant first; a
//   negative value starts with a minus sign, zero gives a single '0', and the
//   final character of each number has m_tlast high. One value gives 1 to 11
//   beats.
//   The block takes one value at a time: s_tready is high only when the
//   previous number has been fully sent. After a value is accepted, the
//   binary to BCD converter shifts in all 32 input bits, one per cycle,
//   through the per-digit add-3 cells and the shift register, then the
//   sequencer sends one character per cycle while m_tready is high. s_tready
//   rises after the last beat is taken, once the output valid flag has
//   cleared and the control state has returned to idle.
//   When the receiver holds m_tready low, the current beat stays in the
//   output register and the sequencer waits; nothing is dropped.
//   Synchronous reset rst clears the sequencer and the output valid flag; the
//   block is ready for a value in the first cycle after reset.
`timescale 1ns / 1ps

module signed_int_to_decimal_ascii_core
  import sitda_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // [31:0] value
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,   // [5:0] character, [7:6] zero
  output logic        m_tlast
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_CONV = 2'd1;
  localparam logic [1:0] ST_EMIT = 2'd2;

  logic [1:0]         state;
  logic [1:0]         state_next;
  logic               neg;
  logic               accept;
  logic [VALUE_W-1:0] mag;
  logic               conv_done;
  bcd_t               conv_bcd;
  logic               emit_busy;
  num_t               num;

  assign s_tready = (state == ST_IDLE);
  assign accept   = s_tvalid && s_tready;
  // Unsigned negate keeps the most negative value exact.
  assign mag      = s_tdata[VALUE_W-1] ? (VALUE_W'(0) - s_tdata) : s_tdata;
  assign num      = '{neg: neg, bcd: conv_bcd};

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept) state_next = ST_CONV;
      end
      ST_CONV: begin
        if (conv_done) state_next = ST_EMIT;
      end
      ST_EMIT: begin
        if (!emit_busy) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      neg <= s_tdata[VALUE_W-1];
    end
  end

  sitda_bcd u_bcd (
    .clk   (clk),
    .rst   (rst),
    .start (accept),
    .mag   (mag),
    .done  (conv_done),
    .bcd   (conv_bcd)
  );

  sitda_emit u_emit (
    .clk      (clk),
    .rst      (rst),
    .start    (conv_done),
    .num      (num),
    .busy     (emit_busy),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

endmodule
